// File: hw/rtl/irpde_pkg.sv
// ----------------------------------------------------------------------------
// irpde_pkg
// Shared types and constants of the infrared pulse-distance encoder.
// ----------------------------------------------------------------------------
package irpde_pkg;

  localparam int BITS_PER_BYTE         = 8;
  localparam int BIT_CNT_BITS          = $clog2(BITS_PER_BYTE);
  localparam int DURATION_BITS_DEFAULT = 14;
  localparam int QUEUE_DEPTH_DEFAULT   = 2;
  localparam int CFG_INDEX_BITS        = 3;

  localparam int LEADER_MARK_RESET  = 9000;
  localparam int LEADER_SPACE_RESET = 4560;
  localparam int BIT_MARK_RESET     = 500;
  localparam int ZERO_SPACE_RESET   = 500;
  localparam int ONE_SPACE_RESET    = 1800;
  localparam int STOP_MARK_RESET    = 560;

  localparam logic LEVEL_MARK  = 1'b0;
  localparam logic LEVEL_SPACE = 1'b1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_LEADER_MARK  = 3'd0,
    REG_LEADER_SPACE = 3'd1,
    REG_BIT_MARK     = 3'd2,
    REG_ZERO_SPACE   = 3'd3,
    REG_ONE_SPACE    = 3'd4,
    REG_STOP_MARK    = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD_MARK,
    PH_LEAD_SPACE,
    PH_BIT_MARK,
    PH_BIT_SPACE,
    PH_STOP
  } phase_t;

  typedef struct packed {
    logic [BITS_PER_BYTE-1:0] data;
    logic                     leader;
    logic                     stop;
  } cmd_t;

endpackage

// File: hw/rtl/irpde_in_if.sv
// ----------------------------------------------------------------------------
// irpde_in_if
// Byte channel: one data byte and an end-of-frame flag per transfer.
// ----------------------------------------------------------------------------
interface irpde_in_if;
  logic                                valid;
  logic                                ready;
  logic [irpde_pkg::BITS_PER_BYTE-1:0] data_byte;
  logic                                frame_end;

  modport source(output valid, output data_byte, output frame_end, input ready);
  modport sink(input valid, input data_byte, input frame_end, output ready);
endinterface

// File: hw/rtl/irpde_out_if.sv
// ----------------------------------------------------------------------------
// irpde_out_if
// Segment channel: a line level and its hold time per transfer.
// ----------------------------------------------------------------------------
interface irpde_out_if #(
  parameter int DURATION_BITS = irpde_pkg::DURATION_BITS_DEFAULT
);
  logic                     valid;
  logic                     ready;
  logic                     line_level;
  logic [DURATION_BITS-1:0] duration_us;
  logic                     last_segment;

  modport source(output valid, output line_level, output duration_us,
                 output last_segment, input ready);
  modport sink(input valid, input line_level, input duration_us,
               input last_segment, output ready);
endinterface

// File: hw/rtl/ir_pulse_distance_encoder_core.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_encoder_core
// Pulse-distance infrared line encoder: bytes in, timed line segments out.
// ----------------------------------------------------------------------------
// Each byte transfer yields 16 segments (mark and space per bit, LSB first),
// plus 2 leader segments on the first byte of a frame and 1 stop mark on the
// byte flagged frame_end, so 16 to 19 segments. The sequencer emits one
// segment per cycle into a registered output while segments.ready does not
// hold it off; a command queue, two entries deep by default, lets the next
// byte be taken while the current one is still being sent. Timing registers
// are written through cfg_wr_en/cfg_index/cfg_data; the user must write them
// only while the block is idle, as the block itself does not enforce this.
// Unknown indexes are ignored.
module ir_pulse_distance_encoder_core #(
  parameter int DURATION_BITS = irpde_pkg::DURATION_BITS_DEFAULT,
  parameter int QUEUE_DEPTH   = irpde_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [irpde_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [DURATION_BITS-1:0]             cfg_data,
  irpde_in_if.sink                             bytes,
  irpde_out_if.source                          segments
);

  logic            front_valid;
  logic            front_ready;
  irpde_pkg::cmd_t front_cmd;
  logic            back_valid;
  logic            back_ready;
  irpde_pkg::cmd_t back_cmd;

  irpde_front u_front (
    .clk       (clk),
    .rst       (rst),
    .bytes     (bytes),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  irpde_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_cmd    (front_cmd),
    .out_valid (back_valid),
    .out_ready (back_ready),
    .out_cmd   (back_cmd)
  );

  irpde_back #(
    .DURATION_BITS (DURATION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .segments  (segments)
  );

endmodule

// File: hw/rtl/irpde_front.sv
// ----------------------------------------------------------------------------
// irpde_front
// Accepts bytes, tracks the open frame and tags each byte with leader and
// stop requests.
// ----------------------------------------------------------------------------
module irpde_front (
  input  logic             clk,
  input  logic             rst,
  irpde_in_if.sink         bytes,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output irpde_pkg::cmd_t  cmd
);

  logic in_frame;
  logic in_frame_next;
  logic accept;

  assign accept      = bytes.valid && cmd_ready;
  assign bytes.ready = cmd_ready;
  assign cmd_valid   = bytes.valid;

  always_comb begin
    cmd.data   = bytes.data_byte;
    cmd.leader = !in_frame;
    cmd.stop   = bytes.frame_end;
  end

  always_comb begin
    in_frame_next = in_frame;
    if (accept) begin
      in_frame_next = !bytes.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
    end else begin
      in_frame <= in_frame_next;
    end
  end

endmodule

// File: hw/rtl/irpde_queue.sv
// ----------------------------------------------------------------------------
// irpde_queue
// Short command queue between the byte front end and the segment sequencer.
// ----------------------------------------------------------------------------
module irpde_queue #(
  parameter int DEPTH = irpde_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  irpde_pkg::cmd_t in_cmd,
  output logic            out_valid,
  input  logic            out_ready,
  output irpde_pkg::cmd_t out_cmd
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  irpde_pkg::cmd_t     mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                push;
  logic                pop;

  assign in_ready  = count != CNT_BITS'(DEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/irpde_back.sv
// ----------------------------------------------------------------------------
// irpde_back
// Timing registers and segment sequencer: turns each command into leader,
// bit and stop segments into a registered output, one per unstalled cycle.
// ----------------------------------------------------------------------------
module irpde_back #(
  parameter int DURATION_BITS = irpde_pkg::DURATION_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [irpde_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [DURATION_BITS-1:0]             cfg_data,
  input  logic                                 cmd_valid,
  output logic                                 cmd_ready,
  input  irpde_pkg::cmd_t                      cmd,
  irpde_out_if.source                          segments
);

  localparam int CNT_BITS = irpde_pkg::BIT_CNT_BITS;

  logic [DURATION_BITS-1:0] leader_mark_us;
  logic [DURATION_BITS-1:0] leader_space_us;
  logic [DURATION_BITS-1:0] bit_mark_us;
  logic [DURATION_BITS-1:0] zero_space_us;
  logic [DURATION_BITS-1:0] one_space_us;
  logic [DURATION_BITS-1:0] stop_mark_us;

  irpde_pkg::phase_t        phase;
  irpde_pkg::phase_t        phase_next;
  irpde_pkg::phase_t        start_phase;
  logic [irpde_pkg::BITS_PER_BYTE-1:0] data;
  logic                     stop;
  logic [CNT_BITS-1:0]      bit_cnt;
  logic                     last_bit;

  logic                     advance;
  logic                     pop;
  logic                     emit;
  logic                     gen_level;
  logic [DURATION_BITS-1:0] gen_dur;
  logic                     gen_last;

  logic                     seg_valid;
  logic                     seg_level;
  logic [DURATION_BITS-1:0] seg_dur;
  logic                     seg_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      leader_mark_us  <= DURATION_BITS'(irpde_pkg::LEADER_MARK_RESET);
      leader_space_us <= DURATION_BITS'(irpde_pkg::LEADER_SPACE_RESET);
      bit_mark_us     <= DURATION_BITS'(irpde_pkg::BIT_MARK_RESET);
      zero_space_us   <= DURATION_BITS'(irpde_pkg::ZERO_SPACE_RESET);
      one_space_us    <= DURATION_BITS'(irpde_pkg::ONE_SPACE_RESET);
      stop_mark_us    <= DURATION_BITS'(irpde_pkg::STOP_MARK_RESET);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        irpde_pkg::REG_LEADER_MARK:  leader_mark_us  <= cfg_data;
        irpde_pkg::REG_LEADER_SPACE: leader_space_us <= cfg_data;
        irpde_pkg::REG_BIT_MARK:     bit_mark_us     <= cfg_data;
        irpde_pkg::REG_ZERO_SPACE:   zero_space_us   <= cfg_data;
        irpde_pkg::REG_ONE_SPACE:    one_space_us    <= cfg_data;
        irpde_pkg::REG_STOP_MARK:    stop_mark_us    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign advance     = !seg_valid || segments.ready;
  assign last_bit    = bit_cnt == CNT_BITS'(irpde_pkg::BITS_PER_BYTE - 1);
  assign start_phase = cmd.leader ? irpde_pkg::PH_LEAD_MARK : irpde_pkg::PH_BIT_MARK;

  // segment generation and command pop
  always_comb begin
    gen_level = irpde_pkg::LEVEL_MARK;
    gen_dur   = bit_mark_us;
    gen_last  = 1'b0;
    emit      = 1'b0;
    pop       = 1'b0;
    case (phase)
      irpde_pkg::PH_IDLE: begin
        pop = 1'b1;
      end
      irpde_pkg::PH_LEAD_MARK: begin
        gen_dur = leader_mark_us;
        emit    = advance;
      end
      irpde_pkg::PH_LEAD_SPACE: begin
        gen_level = irpde_pkg::LEVEL_SPACE;
        gen_dur   = leader_space_us;
        emit      = advance;
      end
      irpde_pkg::PH_BIT_MARK: begin
        emit = advance;
      end
      irpde_pkg::PH_BIT_SPACE: begin
        gen_level = irpde_pkg::LEVEL_SPACE;
        gen_dur   = data[bit_cnt] ? one_space_us : zero_space_us;
        gen_last  = last_bit && !stop;
        emit      = advance;
        pop       = advance && gen_last;
      end
      irpde_pkg::PH_STOP: begin
        gen_dur  = stop_mark_us;
        gen_last = 1'b1;
        emit     = advance;
        pop      = advance;
      end
      default: begin
      end
    endcase
  end

  assign cmd_ready = pop;

  always_comb begin
    phase_next = phase;
    case (phase)
      irpde_pkg::PH_IDLE: begin
        if (cmd_valid) begin
          phase_next = start_phase;
        end
      end
      irpde_pkg::PH_LEAD_MARK: begin
        if (advance) begin
          phase_next = irpde_pkg::PH_LEAD_SPACE;
        end
      end
      irpde_pkg::PH_LEAD_SPACE: begin
        if (advance) begin
          phase_next = irpde_pkg::PH_BIT_MARK;
        end
      end
      irpde_pkg::PH_BIT_MARK: begin
        if (advance) begin
          phase_next = irpde_pkg::PH_BIT_SPACE;
        end
      end
      irpde_pkg::PH_BIT_SPACE: begin
        if (advance) begin
          if (!last_bit) begin
            phase_next = irpde_pkg::PH_BIT_MARK;
          end else if (stop) begin
            phase_next = irpde_pkg::PH_STOP;
          end else if (cmd_valid) begin
            phase_next = start_phase;
          end else begin
            phase_next = irpde_pkg::PH_IDLE;
          end
        end
      end
      irpde_pkg::PH_STOP: begin
        if (advance) begin
          phase_next = cmd_valid ? start_phase : irpde_pkg::PH_IDLE;
        end
      end
      default: phase_next = irpde_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= irpde_pkg::PH_IDLE;
      bit_cnt <= '0;
    end else begin
      phase <= phase_next;
      if (pop && cmd_valid) begin
        bit_cnt <= '0;
      end else if (phase == irpde_pkg::PH_BIT_SPACE && advance) begin
        bit_cnt <= bit_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cmd_valid) begin
      data <= cmd.data;
      stop <= cmd.stop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
    end else if (emit) begin
      seg_valid <= 1'b1;
    end else if (segments.ready) begin
      seg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      seg_level <= gen_level;
      seg_dur   <= gen_dur;
      seg_last  <= gen_last;
    end
  end

  assign segments.valid        = seg_valid;
  assign segments.line_level   = seg_level;
  assign segments.duration_us  = seg_dur;
  assign segments.last_segment = seg_last;

endmodule
